[rtl/pbf_pkg.sv]
// Shared types, codes and helpers for the packet ban filter.
package pbf_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;

	// Request codes carried on req_type.
	localparam logic [2:0] REQ_FRAME_BYTE = 3'd0;
	localparam logic [2:0] REQ_ADD_BANNED = 3'd1;
	localparam logic [2:0] REQ_ADD_RECENT = 3'd2;
	localparam logic [2:0] REQ_DEL_BANNED = 3'd3;
	localparam logic [2:0] REQ_DEL_RECENT = 3'd4;

	// Status codes of a table acknowledge.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Result kinds.
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	// Table selection.
	localparam logic SEL_BANNED = 1'b0;
	localparam logic SEL_RECENT = 1'b1;

	localparam logic [15:0] ETH_IPV4      = 16'h0800;
	localparam logic [15:0] ETH_IPV6      = 16'h86DD;
	localparam logic [15:0] FRAG_MASK     = 16'h3FFF;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_V6_FRAG = 8'd44;
	localparam logic [5:0]  FULL_PLEN     = 6'd32;

	// Work a token asks of every cell it passes.
	typedef enum logic [1:0] {
		OP_MATCH = 2'd0,
		OP_SCAN  = 2'd1,
		OP_CLAIM = 2'd2
	} cell_op_t;

	// Token that walks the cell chain, with the flags it gathers.
	typedef struct packed {
		logic        vld;
		cell_op_t    op;
		logic        sel;
		logic        del;
		logic        kill_rec;
		logic [31:0] addr;
		logic [5:0]  plen;
		logic        hit_b;
		logic        hit_r;
		logic        found;
		logic        rec_found;
		logic        claimed;
	} tok_t;

	// Mask of the top len bits; lengths of 32 and above give all ones.
	function automatic logic [31:0] pfx_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = 32'd0;
		end else if (len >= FULL_PLEN) begin
			m = 32'hFFFF_FFFF;
		end else begin
			m = 32'hFFFF_FFFF << (6'd32 - len);
		end
		return m;
	endfunction

endpackage

[rtl/packet_ban_filter_unit.sv]
// Top level of the packet ban filter: frame parser, controller and cell chain.
// A frame byte other than the last leaves the unit idle. A table lookup walks a
// token through a chain of TABLE_DEPTH cells, one cell per cycle. A frame verdict
// without lookup is settled in the judge state; an unknown request type is
// dropped without a result. A prefix check takes one pass, a promotion up to
// three, an insert up to two and a delete one. One item is in work at a time;
// the next is taken while the previous result waits in the output register.
module packet_ban_filter_unit #(
	parameter int TABLE_DEPTH = pbf_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [7:0]  pkt_byte,
	input  logic        pkt_last,
	input  logic [31:0] entry_addr,
	input  logic [5:0]  entry_prefix_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic        verdict,
	output logic [1:0]  op_status,
	output logic        promoted,
	output logic [31:0] fragment_drops
);
	import pbf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_JUDGE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	typedef enum logic [5:0] {
		PH_MATCH     = 6'b000001,
		PH_INS_SCAN  = 6'b000010,
		PH_DEL_SCAN  = 6'b000100,
		PH_INS_CLAIM = 6'b001000,
		PH_PRO_SCAN  = 6'b010000,
		PH_PRO_CLAIM = 6'b100000
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	tok_t        chain [0:TABLE_DEPTH];
	tok_t        tok0_q;
	logic [5:0]  pos_q, last_q;
	logic [15:0] eth_q, frag_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [1:0]  finrst_q;
	logic [31:0] count_q;
	logic        rk_q, vd_q, pr_q;
	logic [1:0]  st_q;
	logic        out_vld_q, ok_q, vd_o_q, pr_o_q;
	logic [1:0]  st_o_q;
	logic [31:0] fd_o_q;
	logic        acc;
	logic        load_res;
	logic [5:0]  req_plen;
	logic [31:0] req_addr;
	tok_t        ret;

	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && !in_stall;
	assign load_res = (state_q == S_RESP) && (!out_vld_q || !out_stall);
	assign req_plen = (entry_prefix_len > FULL_PLEN) ? FULL_PLEN : entry_prefix_len;
	assign req_addr = entry_addr & pfx_mask(req_plen);
	assign ret      = chain[TABLE_DEPTH];

	// The cell chain holding both tables.
	assign chain[0] = tok0_q;
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		pbf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[i]),
			.tok_out(chain[i+1])
		);
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_res) begin
			out_vld_q <= 1'b1;
		end else if (out_vld_q && !out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// Controller and frame parser.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_MATCH;
			tok0_q    <= '0;
			pos_q     <= '0;
			last_q    <= '0;
			eth_q     <= '0;
			frag_q    <= '0;
			proto_q   <= '0;
			src_q     <= '0;
			finrst_q  <= '0;
			count_q   <= '0;
			rk_q      <= 1'b0;
			vd_q      <= 1'b0;
			pr_q      <= 1'b0;
			st_q      <= ST_DONE;
		end else begin
			tok0_q.vld <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc && req_type == REQ_FRAME_BYTE) begin
						unique case (pos_q)
							6'd12: eth_q[15:8] <= pkt_byte;
							6'd13: eth_q[7:0] <= pkt_byte;
							6'd20: begin
								frag_q[15:8] <= pkt_byte;
								if (eth_q == ETH_IPV6) proto_q <= pkt_byte;
							end
							6'd21: frag_q[7:0] <= pkt_byte;
							6'd23: if (eth_q == ETH_IPV4) proto_q <= pkt_byte;
							6'd26, 6'd27, 6'd28, 6'd29: src_q <= {src_q[23:0], pkt_byte};
							6'd47: finrst_q <= {pkt_byte[2], pkt_byte[0]};
							default: ;
						endcase
						if (pkt_last) begin
							last_q  <= pos_q;
							rk_q    <= KIND_VERDICT;
							vd_q    <= 1'b0;
							pr_q    <= 1'b0;
							st_q    <= ST_DONE;
							state_q <= S_JUDGE;
						end else if (pos_q < 6'd63) begin
							pos_q <= pos_q + 6'd1;
						end
					end else if (acc && req_type >= REQ_ADD_BANNED
							&& req_type <= REQ_DEL_RECENT) begin
						tok0_q      <= '0;
						tok0_q.vld  <= 1'b1;
						tok0_q.op   <= OP_SCAN;
						tok0_q.sel  <= (req_type == REQ_ADD_BANNED
							|| req_type == REQ_DEL_BANNED) ? SEL_BANNED : SEL_RECENT;
						tok0_q.del  <= (req_type == REQ_DEL_BANNED
							|| req_type == REQ_DEL_RECENT);
						tok0_q.addr <= req_addr;
						tok0_q.plen <= req_plen;
						phase_q     <= (req_type == REQ_ADD_BANNED
							|| req_type == REQ_ADD_RECENT) ? PH_INS_SCAN : PH_DEL_SCAN;
						rk_q        <= KIND_ACK;
						vd_q        <= 1'b0;
						pr_q        <= 1'b0;
						state_q     <= S_WAIT;
					end
				end
				S_JUDGE: begin
					// Header checks that settle the verdict without a lookup, or else launch the lookup.
					priority if (last_q < 6'd13) begin
						state_q <= S_RESP;
					end else if (eth_q == ETH_IPV4) begin
						if (last_q < 6'd33) begin
							state_q <= S_RESP;
						end else if ((frag_q & FRAG_MASK) != 16'd0) begin
							count_q <= count_q + 32'd1;
							vd_q    <= 1'b1;
							state_q <= S_RESP;
						end else begin
							tok0_q      <= '0;
							tok0_q.vld  <= 1'b1;
							tok0_q.op   <= OP_MATCH;
							tok0_q.addr <= src_q;
							tok0_q.plen <= FULL_PLEN;
							phase_q     <= PH_MATCH;
							state_q     <= S_WAIT;
						end
					end else if (eth_q == ETH_IPV6 && last_q >= 6'd53
							&& proto_q == PROTO_V6_FRAG) begin
						count_q <= count_q + 32'd1;
						vd_q    <= 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_WAIT: begin
					// Act on the token returning from the chain.
					if (ret.vld) begin
						unique case (phase_q)
							PH_MATCH: begin
								if (ret.hit_b) begin
									vd_q    <= 1'b1;
									state_q <= S_RESP;
								end else if (ret.hit_r && proto_q == PROTO_TCP
										&& last_q >= 6'd53 && finrst_q != 2'd0) begin
									tok0_q          <= '0;
									tok0_q.vld      <= 1'b1;
									tok0_q.op       <= OP_SCAN;
									tok0_q.sel      <= SEL_BANNED;
									tok0_q.kill_rec <= 1'b1;
									tok0_q.addr     <= src_q;
									tok0_q.plen     <= FULL_PLEN;
									phase_q         <= PH_PRO_SCAN;
								end else begin
									state_q <= S_RESP;
								end
							end
							PH_INS_SCAN, PH_PRO_SCAN: begin
								if (ret.found) begin
									pr_q    <= (phase_q == PH_PRO_SCAN);
									st_q    <= ST_DONE;
									state_q <= S_RESP;
								end else begin
									tok0_q       <= '0;
									tok0_q.vld   <= 1'b1;
									tok0_q.op    <= OP_CLAIM;
									tok0_q.sel   <= ret.sel;
									tok0_q.addr  <= ret.addr;
									tok0_q.plen  <= ret.plen;
									phase_q      <= (phase_q == PH_PRO_SCAN)
										? PH_PRO_CLAIM : PH_INS_CLAIM;
								end
							end
							PH_DEL_SCAN: begin
								st_q    <= ret.found ? ST_DONE : ST_NOT_FOUND;
								state_q <= S_RESP;
							end
							PH_INS_CLAIM: begin
								st_q    <= ret.claimed ? ST_DONE : ST_FULL;
								state_q <= S_RESP;
							end
							PH_PRO_CLAIM: begin
								pr_q    <= ret.claimed;
								state_q <= S_RESP;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_RESP: begin
					// Hand the result over once the output register is free.
					if (load_res) begin
						state_q <= S_IDLE;
						if (rk_q == KIND_VERDICT) begin
							pos_q    <= '0;
							eth_q    <= '0;
							frag_q   <= '0;
							proto_q  <= '0;
							src_q    <= '0;
							finrst_q <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load_res) begin
			ok_q   <= rk_q;
			vd_o_q <= vd_q;
			st_o_q <= (rk_q == KIND_ACK) ? st_q : ST_DONE;
			pr_o_q <= pr_q;
			fd_o_q <= count_q;
		end
	end

	assign out_valid      = out_vld_q;
	assign result_kind    = ok_q;
	assign verdict        = vd_o_q;
	assign op_status      = st_o_q;
	assign promoted       = pr_o_q;
	assign fragment_drops = fd_o_q;

`ifndef SYNTHESIS
	a_ret_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ret.vld |-> state_q == S_WAIT)
		else $error("token returned from chain outside wait state");
	a_resp_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && !out_vld_q) |=> out_vld_q)
		else $error("result not loaded into free output register");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 32'd1))
		else $error("fragment counter moved by more than one");
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok0_q.vld |-> state_q == S_WAIT)
		else $error("token launched without waiting for it");
`endif

endmodule

[rtl/pbf_cell.sv]
// One cell of the chain: one banned and one recent table entry.
module pbf_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  pbf_pkg::tok_t tok_in,
	output pbf_pkg::tok_t tok_out
);
	import pbf_pkg::*;

	logic        bv_q, rv_q;
	logic [5:0]  bl_q, rl_q;
	logic [31:0] ba_q, ra_q;
	tok_t        tok_q;
	tok_t        nxt;
	logic        b_m, r_m, b_x, r_x, sel_v, sel_x;
	logic        b_clr, r_clr, b_set, r_set;

	// Compare the passing token with the held entries.
	always_comb begin
		nxt   = tok_in;
		b_m   = bv_q && ((tok_in.addr & pfx_mask(bl_q)) == ba_q);
		r_m   = rv_q && ((tok_in.addr & pfx_mask(rl_q)) == ra_q);
		b_x   = bv_q && (bl_q == tok_in.plen) && (ba_q == tok_in.addr);
		r_x   = rv_q && (rl_q == tok_in.plen) && (ra_q == tok_in.addr);
		sel_v = (tok_in.sel == SEL_RECENT) ? rv_q : bv_q;
		sel_x = (tok_in.sel == SEL_RECENT) ? r_x : b_x;
		b_clr = 1'b0;
		r_clr = 1'b0;
		b_set = 1'b0;
		r_set = 1'b0;
		if (tok_in.vld) begin
			unique case (tok_in.op)
				OP_MATCH: begin
					nxt.hit_b = tok_in.hit_b | b_m;
					nxt.hit_r = tok_in.hit_r | r_m;
				end
				OP_SCAN: begin
					if (sel_x && !tok_in.found) begin
						nxt.found = 1'b1;
						if (tok_in.del) begin
							b_clr = (tok_in.sel == SEL_BANNED);
							r_clr = (tok_in.sel == SEL_RECENT);
						end
					end
					if (tok_in.kill_rec && r_x && !tok_in.rec_found) begin
						nxt.rec_found = 1'b1;
						r_clr         = 1'b1;
					end
				end
				OP_CLAIM: begin
					if (!sel_v && !tok_in.claimed) begin
						nxt.claimed = 1'b1;
						b_set       = (tok_in.sel == SEL_BANNED);
						r_set       = (tok_in.sel == SEL_RECENT);
					end
				end
				default: ;
			endcase
		end
	end

	// Valid bits and the token register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q  <= 1'b0;
			rv_q  <= 1'b0;
			tok_q <= '0;
		end else begin
			if (b_set) bv_q <= 1'b1;
			else if (b_clr) bv_q <= 1'b0;
			if (r_set) rv_q <= 1'b1;
			else if (r_clr) rv_q <= 1'b0;
			tok_q <= nxt;
		end
	end

	// Entry contents.
	always_ff @(posedge clk) begin
		if (b_set) begin
			bl_q <= tok_in.plen;
			ba_q <= tok_in.addr;
		end
		if (r_set) begin
			rl_q <= tok_in.plen;
			ra_q <= tok_in.addr;
		end
	end

	assign tok_out = tok_q;

endmodule

[dv/packet_ban_filter_unit_test.sv]
// Self-checking testbench for the packet ban filter unit.
`timescale 1ns / 1ps

module packet_ban_filter_unit_test;
	import pbf_pkg::*;

	localparam int DEPTH = 64;
	localparam int N_RANDOM = 1000;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [2:0]  rtype;
		logic [7:0]  data;
		logic        last;
		logic [31:0] addr;
		logic [5:0]  plen;
	} req_t;

	typedef struct {
		logic        kind;
		logic        verd;
		logic [1:0]  status;
		logic        promo;
		logic [31:0] drops;
	} res_t;

	typedef struct {
		bit          valid [DEPTH];
		logic [5:0]  plen [DEPTH];
		logic [31:0] addr [DEPTH];
	} prefix_tbl_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  req_type;
	logic [7:0]  pkt_byte;
	logic        pkt_last;
	logic [31:0] entry_addr;
	logic [5:0]  entry_prefix_len;
	logic        out_valid;
	logic        out_stall;
	logic        result_kind;
	logic        verdict;
	logic [1:0]  op_status;
	logic        promoted;
	logic [31:0] fragment_drops;

	req_t        pending_reqs [$];
	res_t        expected_results [$];
	int          mismatch_count;
	bit          stimulus_done;
	int          idle_cycles;

	// Filter state mirrored by the predictor.
	prefix_tbl_t banned_tbl;
	prefix_tbl_t recent_tbl;
	logic [5:0]  byte_pos;
	logic [15:0] eth_type;
	logic [15:0] frag_word;
	logic [7:0]  proto;
	logic [31:0] src_ip;
	logic [1:0]  fin_rst;
	logic [31:0] frag_drops;

	packet_ban_filter_unit u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .pkt_byte(pkt_byte), .pkt_last(pkt_last),
		.entry_addr(entry_addr), .entry_prefix_len(entry_prefix_len),
		.out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
		.verdict(verdict), .op_status(op_status), .promoted(promoted),
		.fragment_drops(fragment_drops)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] mask_of(input logic [5:0] len);
		if (len == 6'd0) return 32'd0;
		if (len >= 6'd32) return 32'hFFFF_FFFF;
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	function automatic bit tbl_covers(input prefix_tbl_t t, input logic [31:0] a);
		for (int i = 0; i < DEPTH; i++) begin
			if (t.valid[i] && ((a & mask_of(t.plen[i])) == t.addr[i])) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int tbl_index(input prefix_tbl_t t, input logic [5:0] len,
			input logic [31:0] a);
		for (int i = 0; i < DEPTH; i++) begin
			if (t.valid[i] && t.plen[i] == len && t.addr[i] == a) return i;
		end
		return -1;
	endfunction

	function automatic logic [1:0] tbl_add(inout prefix_tbl_t t, input logic [5:0] len,
			input logic [31:0] a);
		logic [5:0] l;
		l = (len > 6'd32) ? 6'd32 : len;
		a = a & mask_of(l);
		if (tbl_index(t, l, a) >= 0) return ST_DONE;
		for (int i = 0; i < DEPTH; i++) begin
			if (!t.valid[i]) begin
				t.valid[i] = 1'b1;
				t.plen[i] = l;
				t.addr[i] = a;
				return ST_DONE;
			end
		end
		return ST_FULL;
	endfunction

	function automatic logic [1:0] tbl_remove(inout prefix_tbl_t t, input logic [5:0] len,
			input logic [31:0] a);
		logic [5:0] l;
		int k;
		l = (len > 6'd32) ? 6'd32 : len;
		a = a & mask_of(l);
		k = tbl_index(t, l, a);
		if (k < 0) return ST_NOT_FOUND;
		t.valid[k] = 1'b0;
		t.plen[k] = '0;
		t.addr[k] = '0;
		return ST_DONE;
	endfunction

	// Frame verdict at the final byte, given the index of that byte.
	function automatic logic judge_frame(input logic [5:0] last_idx, output logic promo);
		promo = 1'b0;
		if (last_idx < 13) return 1'b0;
		if (eth_type == ETH_IPV4) begin
			if (last_idx < 33) return 1'b0;
			if ((frag_word & FRAG_MASK) != 0) begin
				frag_drops++;
				return 1'b1;
			end
			if (tbl_covers(banned_tbl, src_ip)) return 1'b1;
			if (tbl_covers(recent_tbl, src_ip) && proto == PROTO_TCP && last_idx >= 53
					&& fin_rst != 0) begin
				if (tbl_add(banned_tbl, FULL_PLEN, src_ip) == ST_DONE) promo = 1'b1;
				void'(tbl_remove(recent_tbl, FULL_PLEN, src_ip));
			end
			return 1'b0;
		end
		if (eth_type == ETH_IPV6 && last_idx >= 53 && proto == PROTO_V6_FRAG) begin
			frag_drops++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Predict the result of one accepted transfer.
	task automatic predict_filter(input req_t r);
		res_t e;
		logic [5:0] p;
		logic promo;
		e = '{default: '0};
		if (r.rtype == REQ_FRAME_BYTE) begin
			p = byte_pos;
			case (p)
				6'd12: eth_type[15:8] = r.data;
				6'd13: eth_type[7:0] = r.data;
				6'd20: begin
					frag_word[15:8] = r.data;
					if (eth_type == ETH_IPV6) proto = r.data;
				end
				6'd21: frag_word[7:0] = r.data;
				6'd23: if (eth_type == ETH_IPV4) proto = r.data;
				6'd26, 6'd27, 6'd28, 6'd29: src_ip = {src_ip[23:0], r.data};
				6'd47: fin_rst = {r.data[2], r.data[0]};
				default: ;
			endcase
			if (!r.last) begin
				if (byte_pos < 63) byte_pos++;
				return;
			end
			e.kind = KIND_VERDICT;
			e.verd = judge_frame(p, promo);
			e.promo = promo;
			byte_pos = '0; eth_type = '0; frag_word = '0; proto = '0;
			src_ip = '0; fin_rst = '0;
		end else if (r.rtype > REQ_DEL_RECENT) begin
			return;
		end else begin
			e.kind = KIND_ACK;
			case (r.rtype)
				REQ_ADD_BANNED: e.status = tbl_add(banned_tbl, r.plen, r.addr);
				REQ_ADD_RECENT: e.status = tbl_add(recent_tbl, r.plen, r.addr);
				REQ_DEL_BANNED: e.status = tbl_remove(banned_tbl, r.plen, r.addr);
				default: e.status = tbl_remove(recent_tbl, r.plen, r.addr);
			endcase
		end
		e.drops = frag_drops;
		expected_results.push_back(e);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
		mismatch_count++;
	endtask

	function automatic req_t table_req(input logic [2:0] t, input logic [31:0] a,
			input logic [5:0] l);
		return '{rtype: t, data: 8'($urandom), last: 1'($urandom), addr: a, plen: l};
	endfunction

	// Queue one frame; bytes outside the given fields take random values.
	task automatic push_frame(input int len, input logic [15:0] et, input logic [15:0] frag,
			input logic [7:0] pr, input logic [31:0] src, input logic [7:0] flags);
		req_t r;
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			case (i)
				12: b = et[15:8];
				13: b = et[7:0];
				20: b = frag[15:8];
				21: b = frag[7:0];
				23: b = pr;
				26: b = src[31:24];
				27: b = src[23:16];
				28: b = src[15:8];
				29: b = src[7:0];
				47: b = flags;
				default: ;
			endcase
			r = '{rtype: REQ_FRAME_BYTE, data: b, last: (i == len - 1),
				addr: $urandom, plen: 6'($urandom)};
			pending_reqs.push_back(r);
			// Table traffic inside a frame must not disturb it.
			if ($urandom_range(0, 40) == 0)
				pending_reqs.push_back(table_req(REQ_ADD_RECENT, $urandom, 6'($urandom)));
		end
	endtask

	function automatic logic [31:0] pick_src();
		case ($urandom_range(0, 3))
			0: return {8'd10, 16'($urandom_range(0, 3)), 8'($urandom_range(0, 7))};
			1: return {8'd192, 8'd168, 8'($urandom_range(0, 3)), 8'($urandom)};
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_entry_addr();
		return ($urandom_range(0, 3) == 0) ? $urandom : pick_src();
	endfunction

	// Stimulus.
	initial begin
		int len;
		logic [15:0] et;
		logic [15:0] frag;
		logic [7:0] pr;
		stimulus_done = 1'b0;
		// Directed table and frame cases.
		pending_reqs.push_back(table_req(REQ_DEL_BANNED, 32'h0A00_0000, 6'd8));
		pending_reqs.push_back(table_req(REQ_ADD_BANNED, 32'h0A01_FFFF, 6'd16));
		pending_reqs.push_back(table_req(REQ_ADD_BANNED, 32'h0A01_0000, 6'd16));
		pending_reqs.push_back(table_req(REQ_ADD_RECENT, 32'hC0A8_0005, 6'd63));
		pending_reqs.push_back(table_req(REQ_ADD_RECENT, 32'h0000_0000, 6'd0));
		pending_reqs.push_back(table_req(REQ_DEL_RECENT, 32'h1234_5678, 6'd0));
		pending_reqs.push_back(table_req(3'd5, 32'hFFFF_FFFF, 6'd32));
		pending_reqs.push_back(table_req(3'd7, 32'h0, 6'd0));
		push_frame(1, 16'h0800, 0, 6, 32'hC0A8_0005, 0);
		push_frame(13, 16'h0800, 0, 6, 32'hC0A8_0005, 0);
		push_frame(33, 16'h0800, 0, 6, 32'hC0A8_0005, 0);
		push_frame(34, 16'h0800, 16'h2000, 6, 32'hC0A8_0005, 0);
		push_frame(40, 16'h0800, 16'h1FFF, 6, 32'hC0A8_0005, 0);
		push_frame(60, 16'h0800, 16'h4000, 6, 32'h0A01_2233, 0);
		push_frame(64, 16'h0800, 16'h4000, 6, 32'hC0A8_0005, 8'h01);
		push_frame(54, 16'h0800, 16'h0000, 6, 32'hC0A8_0005, 8'h04);
		push_frame(53, 16'h86DD, 0, 44, 0, 0);
		push_frame(54, 16'h86DD, 16'h2C00, 0, 0, 0);
		push_frame(54, 16'h86DD, 16'h0600, 0, 0, 0);
		push_frame(50, 16'h0806, 16'hFFFF, 6, 0, 0);
		pending_reqs.push_back(table_req(REQ_DEL_BANNED, 32'h0A01_0000, 6'd16));
		pending_reqs.push_back(table_req(REQ_DEL_RECENT, 32'h0, 6'd0));
		// Fill the banned table to overflow, then drain it again.
		for (int i = 0; i < DEPTH + 2; i++)
			pending_reqs.push_back(table_req(REQ_ADD_BANNED, 32'hAC10_0000 + i, 6'd32));
		pending_reqs.push_back(table_req(REQ_ADD_RECENT, 32'hC0A8_0009, 6'd32));
		push_frame(60, 16'h0800, 0, 6, 32'hC0A8_0009, 8'h05);
		for (int i = 0; i < DEPTH; i++)
			pending_reqs.push_back(table_req(REQ_DEL_BANNED, 32'hAC10_0000 + i, 6'd32));
		// Random part: mostly well-formed frames, some table traffic and noise.
		for (int n = 0; n < N_RANDOM; ) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					pending_reqs.push_back(table_req(3'($urandom_range(1, 4)),
						pick_entry_addr(), 6'($urandom_range(0, 4) == 0 ? $urandom :
						$urandom_range(8, 32))));
					n++;
				end
				3: begin
					pending_reqs.push_back(table_req(3'($urandom_range(5, 7)), $urandom,
						6'($urandom)));
				end
				default: begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80) :
						$urandom_range(54, 70);
					case ($urandom_range(0, 5))
						0: et = ETH_IPV6;
						1: et = 16'($urandom);
						default: et = ETH_IPV4;
					endcase
					frag = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'h4000;
					pr = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
						($urandom_range(0, 3) == 0 ? PROTO_V6_FRAG : PROTO_TCP);
					if (et == ETH_IPV6 && $urandom_range(0, 1) == 1) frag[15:8] = pr;
					push_frame(len, et, frag, pr, pick_src(),
						($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'h00);
					n += len;
				end
			endcase
		end
		stimulus_done = 1'b1;
	end

	// Reset and predictor init.
	initial begin
		mismatch_count = 0;
		banned_tbl = '{default: '{default: '0}};
		recent_tbl = '{default: '{default: '0}};
		byte_pos = '0; eth_type = '0; frag_word = '0; proto = '0;
		src_ip = '0; fin_rst = '0; frag_drops = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: bursts of transfers separated by random gaps.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0; pkt_byte <= '0; pkt_last <= 1'b0;
			entry_addr <= '0; entry_prefix_len <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) predict_filter(pending_reqs.pop_front());
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() > 0) begin
					in_valid <= 1'b1;
					req_type <= pending_reqs[0].rtype;
					pkt_byte <= pending_reqs[0].data;
					pkt_last <= pending_reqs[0].last;
					entry_addr <= pending_reqs[0].addr;
					entry_prefix_len <= pending_reqs[0].plen;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold-off early in the run.
	int rx_cycle;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_cycle <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle >= 300 && rx_cycle < 900)
				out_stall <= 1'b1;
			else if ((rx_cycle / 500) % 4 == 3)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// Monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", result_kind, 0);
			end else begin
				e = expected_results.pop_front();
				if (result_kind !== e.kind) report_mismatch("result_kind", result_kind, e.kind);
				if (verdict !== e.verd) report_mismatch("verdict", verdict, e.verd);
				if (op_status !== e.status) report_mismatch("op_status", op_status, e.status);
				if (promoted !== e.promo) report_mismatch("promoted", promoted, e.promo);
				if (fragment_drops !== e.drops)
					report_mismatch("fragment_drops", fragment_drops, e.drops);
			end
		end
	end

	// Watchdog and end of run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		wait (stimulus_done);
		wait (pending_reqs.size() == 0 && expected_results.size() == 0
			|| idle_cycles >= IDLE_LIMIT);
		if (idle_cycles < IDLE_LIMIT) repeat (400) @(posedge clk);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
		end else if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/pbf_pkg.sv
rtl/pbf_cell.sv
rtl/packet_ban_filter_unit.sv
dv/packet_ban_filter_unit_test.sv
